@@ hw/rtl/ecc_pkg.sv @@
`default_nettype none
package ecc_pkg;

  localparam int FLOORS         = 16;
  localparam int MAX_PASSENGERS = 16;
  localparam int FLOOR_W        = 4;
  localparam int PASS_W         = $clog2(MAX_PASSENGERS);
  localparam int CNT_W          = $clog2(MAX_PASSENGERS + 1);
  localparam int ALARM_LEVEL    = 3;
  localparam logic [2:0] COUNT_MAX = 3'd7;

  // input item kinds
  typedef enum logic [2:0] {
    K_TICK     = 3'd0,
    K_CALL     = 3'd1,
    K_OVERLOAD = 3'd2,
    K_FIRE     = 3'd3,
    K_POWER    = 3'd4,
    K_DOOR     = 3'd5,
    K_HELP     = 3'd6
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAFE_FLOOR  = 2'd0,
    CFG_START_FLOOR = 2'd1,
    CFG_START_DIR   = 2'd2
  } cfg_idx_t;

  // direction codes
  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // operation applied to each table entry during the scan
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ARRIVE,
    OP_CALL,
    OP_RETARGET
  } op_t;

  typedef struct packed {
    logic               valid;
    logic               onboard;
    logic [FLOOR_W-1:0] pickup;
    logic [FLOOR_W-1:0] target;
  } entry_t;

  // per-entry request from the sequencer
  typedef struct packed {
    op_t                op;
    logic               board;
    logic               alloc_open;
    logic [FLOOR_W-1:0] floor;
    logic [FLOOR_W-1:0] pick;
    logic [FLOOR_W-1:0] targ;
    logic [FLOOR_W-1:0] safe;
  } unit_req_t;

  // per-entry response to the sequencer
  typedef struct packed {
    logic               take;
    logic               set_en;
    logic [FLOOR_W-1:0] set_floor;
  } unit_rsp_t;

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
    logic [FLOOR_W:0] fe;
    fe = {1'b0, f};
    if (fe < (FLOOR_W+1)'(FLOORS)) return f;
    return FLOOR_W'(FLOORS - 1);
  endfunction

  function automatic logic [1:0] decode_dir(input logic [1:0] v);
    logic [1:0] d;
    unique case (v)
      2'b00:   d = DIR_IDLE;
      2'b01:   d = DIR_UP;
      default: d = DIR_DOWN;
    endcase
    return d;
  endfunction

  function automatic logic [FLOOR_W-1:0] lowest_set(input logic [FLOORS-1:0] m);
    logic [FLOOR_W-1:0] idx;
    idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (m[i]) idx = FLOOR_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ecc_if.sv @@
`default_nettype none
interface ecc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] pickup_floor;
  logic [3:0] target_floor;

  modport source (output valid, kind, pickup_floor, target_floor, input ready);
  modport sink   (input valid, kind, pickup_floor, target_floor, output ready);
endinterface

interface ecc_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        car_floor;
  logic signed [1:0] heading;
  logic              stopped_here;
  logic [4:0]        riders;
  logic [4:0]        waiting;
  logic              door_warning;
  logic              help_alarm;
  logic              overloaded;
  logic              door_blocked;
  logic              emergency;
  logic              call_rejected;

  modport source (output valid, car_floor, heading, stopped_here, riders, waiting,
                  door_warning, help_alarm, overloaded, door_blocked, emergency,
                  call_rejected, input ready);
  modport sink   (input valid, car_floor, heading, stopped_here, riders, waiting,
                  door_warning, help_alarm, overloaded, door_blocked, emergency,
                  call_rejected, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ecc_entry_unit.sv @@
`default_nettype none
module ecc_entry_unit (
  input  wire ecc_pkg::unit_req_t req,
  input  wire ecc_pkg::entry_t    ent,
  output ecc_pkg::entry_t         ent_new,
  output ecc_pkg::unit_rsp_t      rsp
);
  import ecc_pkg::*;

  // update of one passenger entry, shared by every scan step
  always_comb begin
    ent_new = ent;
    rsp     = '0;
    unique case (req.op)
      OP_ARRIVE: begin
        if (ent.valid && ent.onboard && ent.target == req.floor) begin
          ent_new.valid = 1'b0;
        end else if (req.board && ent.valid && !ent.onboard && ent.pickup == req.floor) begin
          ent_new.onboard = 1'b1;
          rsp.set_en      = 1'b1;
          rsp.set_floor   = ent.target;
        end
      end
      OP_CALL: begin
        if (req.alloc_open && !ent.valid) begin
          ent_new.valid   = 1'b1;
          ent_new.pickup  = req.pick;
          ent_new.target  = req.targ;
          ent_new.onboard = (req.pick == req.floor);
          rsp.take        = 1'b1;
          rsp.set_en      = 1'b1;
          rsp.set_floor   = (req.pick == req.floor) ? req.targ : req.pick;
        end
      end
      OP_RETARGET: begin
        if (ent.valid && ent.onboard) ent_new.target = req.safe;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/elevator_car_controller.sv @@
// Elevator car controller. Each input beat (tick, call, hazard event) is taken
// only while the block is idle and yields exactly one result beat. An item
// passes through an accept step, a set-up step, one pass over the passenger
// table through a single shared entry unit at one entry a cycle, and a
// finishing step that settles the direction and loads the output register.
// A new beat is taken while the previous result still waits; the finishing
// step waits for the output register. Configuration writes are applied at once
// and belong in idle periods.
`default_nettype none
module elevator_car_controller (
  input  wire             clk,
  input  wire             rst_n,
  ecc_in_if.sink          in_ch,
  ecc_out_if.source       out_ch,
  input  wire             cfg_we,
  input  wire       [1:0] cfg_index,
  input  wire       [3:0] cfg_data
);
  import ecc_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]          kind_r, kind_nxt;
  logic [FLOOR_W-1:0]  pick_r, pick_nxt, targ_r, targ_nxt;
  logic [FLOOR_W-1:0]  floor_r, floor_nxt, safe_r, safe_nxt;
  logic [1:0]          dir_r, dir_nxt;
  logic [FLOORS-1:0]   mask_r, mask_nxt;
  logic                ovl_r, ovl_nxt, fire_r, fire_nxt, pwr_r, pwr_nxt;
  logic                door_r, door_nxt, help_r, help_nxt;
  logic [2:0]          blk_cnt_r, blk_cnt_nxt, help_cnt_r, help_cnt_nxt;
  logic                arr_r, arr_nxt, board_r, board_nxt;
  logic                alloc_ok_r, alloc_ok_nxt, found_r, found_nxt;
  op_t                 op_r, op_nxt;
  logic [PASS_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    rid_cnt_r, rid_cnt_nxt, wait_cnt_r, wait_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // result register
  logic [3:0]          res_floor_r, res_floor_nxt;
  logic [1:0]          res_dir_r, res_dir_nxt;
  logic                res_stop_r, res_stop_nxt, res_rej_r, res_rej_nxt;
  logic [CNT_W-1:0]    res_rid_r, res_rid_nxt, res_wait_r, res_wait_nxt;
  logic                res_warn_r, res_warn_nxt, res_alarm_r, res_alarm_nxt;
  logic                res_ovl_r, res_ovl_nxt, res_door_r, res_door_nxt;
  logic                res_emerg_r, res_emerg_nxt;

  // passenger table: valid bits reset, payload not
  logic                ent_v_r [MAX_PASSENGERS];
  entry_t              ent_p_r [MAX_PASSENGERS];

  entry_t    ent_cur, ent_new;
  unit_req_t req;
  unit_rsp_t rsp;
  logic      accept, out_free, scan_wr;

  logic [FLOOR_W-1:0] fl_move, low_idx;
  logic [FLOORS-1:0]  mask_fin;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // entry read at the scan index
  always_comb begin
    ent_cur       = ent_p_r[idx_r];
    ent_cur.valid = ent_v_r[idx_r];
  end

  always_comb begin
    req.op         = op_r;
    req.board      = board_r;
    req.alloc_open = alloc_ok_r && !found_r;
    req.floor      = floor_r;
    req.pick       = pick_r;
    req.targ       = targ_r;
    req.safe       = clamp_floor(safe_r);
  end

  ecc_entry_unit u_unit (
    .req     (req),
    .ent     (ent_cur),
    .ent_new (ent_new),
    .rsp     (rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == PASS_W'(MAX_PASSENGERS - 1)) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign scan_wr     = (state_r == ST_SCAN);

  // one floor step in the current direction, stopping at the shaft ends
  always_comb begin
    fl_move = floor_r;
    if (dir_r == DIR_UP && floor_r != FLOOR_W'(FLOORS - 1)) fl_move = floor_r + 1'b1;
    else if (dir_r == DIR_DOWN && floor_r != '0) fl_move = floor_r - 1'b1;
  end

  always_comb begin
    mask_fin = mask_r;
    if (arr_r) mask_fin[floor_r] = 1'b0;
    low_idx = lowest_set(mask_fin);
  end

  // datapath
  always_comb begin
    kind_nxt      = kind_r;
    pick_nxt      = pick_r;
    targ_nxt      = targ_r;
    floor_nxt     = floor_r;
    safe_nxt      = safe_r;
    dir_nxt       = dir_r;
    mask_nxt      = mask_r;
    ovl_nxt       = ovl_r;
    fire_nxt      = fire_r;
    pwr_nxt       = pwr_r;
    door_nxt      = door_r;
    help_nxt      = help_r;
    blk_cnt_nxt   = blk_cnt_r;
    help_cnt_nxt  = help_cnt_r;
    arr_nxt       = arr_r;
    board_nxt     = board_r;
    alloc_ok_nxt  = alloc_ok_r;
    found_nxt     = found_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    rid_cnt_nxt   = rid_cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_floor_nxt = res_floor_r;
    res_dir_nxt   = res_dir_r;
    res_stop_nxt  = res_stop_r;
    res_rej_nxt   = res_rej_r;
    res_rid_nxt   = res_rid_r;
    res_wait_nxt  = res_wait_r;
    res_warn_nxt  = res_warn_r;
    res_alarm_nxt = res_alarm_r;
    res_ovl_nxt   = res_ovl_r;
    res_door_nxt  = res_door_r;
    res_emerg_nxt = res_emerg_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_ch.kind;
          pick_nxt = in_ch.pickup_floor;
          targ_nxt = in_ch.target_floor;
        end
      end
      ST_PREP: begin
        arr_nxt      = 1'b0;
        board_nxt    = 1'b0;
        alloc_ok_nxt = 1'b0;
        found_nxt    = 1'b0;
        op_nxt       = OP_NONE;
        idx_nxt      = '0;
        rid_cnt_nxt  = '0;
        wait_cnt_nxt = '0;
        unique case (kind_r)
          K_TICK: begin
            if (help_r && help_cnt_r != COUNT_MAX) help_cnt_nxt = help_cnt_r + 1'b1;
            if (door_r) begin
              if (blk_cnt_r != COUNT_MAX) blk_cnt_nxt = blk_cnt_r + 1'b1;
            end else if (!ovl_r) begin
              floor_nxt = fl_move;
              if (mask_r[fl_move]) begin
                arr_nxt   = 1'b1;
                board_nxt = !(fire_r || pwr_r);
                op_nxt    = OP_ARRIVE;
              end
            end
          end
          K_CALL: begin
            alloc_ok_nxt = ({1'b0, pick_r} < (FLOOR_W+1)'(FLOORS))
                        && ({1'b0, targ_r} < (FLOOR_W+1)'(FLOORS));
            op_nxt = OP_CALL;
          end
          K_OVERLOAD: ovl_nxt = !ovl_r;
          K_FIRE, K_POWER: begin
            if (kind_r == K_FIRE) fire_nxt = 1'b1;
            else pwr_nxt = 1'b1;
            mask_nxt                   = '0;
            mask_nxt[clamp_floor(safe_r)] = 1'b1;
            op_nxt                     = OP_RETARGET;
          end
          K_DOOR: begin
            door_nxt = !door_r;
            if (door_r) blk_cnt_nxt = '0;
          end
          K_HELP: begin
            help_nxt = !help_r;
            if (help_r) help_cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (rsp.set_en) mask_nxt[rsp.set_floor] = 1'b1;
        if (rsp.take) found_nxt = 1'b1;
        if (ent_new.valid && ent_new.onboard) rid_cnt_nxt = rid_cnt_r + 1'b1;
        if (ent_new.valid && !ent_new.onboard) wait_cnt_nxt = wait_cnt_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          mask_nxt = mask_fin;
          if (kind_r == K_TICK || kind_r == K_CALL || kind_r == K_FIRE
              || kind_r == K_POWER) begin
            if (mask_fin == '0) dir_nxt = DIR_IDLE;
            else if (low_idx > floor_r) dir_nxt = DIR_UP;
            else if (low_idx < floor_r) dir_nxt = DIR_DOWN;
          end
          out_valid_nxt = 1'b1;
          res_floor_nxt = floor_r;
          res_dir_nxt   = dir_nxt;
          res_stop_nxt  = arr_r;
          res_rej_nxt   = (kind_r == K_CALL) && !(alloc_ok_r && found_r);
          res_rid_nxt   = rid_cnt_r;
          res_wait_nxt  = wait_cnt_r;
          res_warn_nxt  = (blk_cnt_r > 3'(ALARM_LEVEL));
          res_alarm_nxt = (help_cnt_r > 3'(ALARM_LEVEL));
          res_ovl_nxt   = ovl_r;
          res_door_nxt  = door_r;
          res_emerg_nxt = fire_r || pwr_r;
        end
      end
      default: begin
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAFE_FLOOR:  safe_nxt  = cfg_data;
        CFG_START_FLOOR: floor_nxt = clamp_floor(cfg_data);
        CFG_START_DIR:   dir_nxt   = decode_dir(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      floor_r     <= '0;
      safe_r      <= FLOOR_W'(1);
      dir_r       <= DIR_IDLE;
      mask_r      <= '0;
      ovl_r       <= 1'b0;
      fire_r      <= 1'b0;
      pwr_r       <= 1'b0;
      door_r      <= 1'b0;
      help_r      <= 1'b0;
      blk_cnt_r   <= '0;
      help_cnt_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      floor_r     <= floor_nxt;
      safe_r      <= safe_nxt;
      dir_r       <= dir_nxt;
      mask_r      <= mask_nxt;
      ovl_r       <= ovl_nxt;
      fire_r      <= fire_nxt;
      pwr_r       <= pwr_nxt;
      door_r      <= door_nxt;
      help_r      <= help_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      help_cnt_r  <= help_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    pick_r      <= pick_nxt;
    targ_r      <= targ_nxt;
    arr_r       <= arr_nxt;
    board_r     <= board_nxt;
    alloc_ok_r  <= alloc_ok_nxt;
    found_r     <= found_nxt;
    op_r        <= op_nxt;
    rid_cnt_r   <= rid_cnt_nxt;
    wait_cnt_r  <= wait_cnt_nxt;
    res_floor_r <= res_floor_nxt;
    res_dir_r   <= res_dir_nxt;
    res_stop_r  <= res_stop_nxt;
    res_rej_r   <= res_rej_nxt;
    res_rid_r   <= res_rid_nxt;
    res_wait_r  <= res_wait_nxt;
    res_warn_r  <= res_warn_nxt;
    res_alarm_r <= res_alarm_nxt;
    res_ovl_r   <= res_ovl_nxt;
    res_door_r  <= res_door_nxt;
    res_emerg_r <= res_emerg_nxt;
  end

  // passenger table write-back at the scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PASSENGERS; i++) ent_v_r[i] <= 1'b0;
    end else if (scan_wr) begin
      ent_v_r[idx_r] <= ent_new.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_wr) ent_p_r[idx_r] <= ent_new;
  end

  // result port
  assign out_ch.valid         = out_valid_r;
  assign out_ch.car_floor     = res_floor_r;
  assign out_ch.heading       = res_dir_r;
  assign out_ch.stopped_here  = res_stop_r;
  assign out_ch.riders        = res_rid_r;
  assign out_ch.waiting       = res_wait_r;
  assign out_ch.door_warning  = res_warn_r;
  assign out_ch.help_alarm    = res_alarm_r;
  assign out_ch.overloaded    = res_ovl_r;
  assign out_ch.door_blocked  = res_door_r;
  assign out_ch.emergency     = res_emerg_r;
  assign out_ch.call_rejected = res_rej_r;

  // checks
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, res_rid_r} + {1'b0, res_wait_r}) <= (CNT_W+1)'(MAX_PASSENGERS))
    else $error("more passengers than table entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken again before the item was processed");

  a_stop_not_call: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stopped_here) |-> !out_ch.call_rejected)
    else $error("stop and call rejection in one result");

endmodule
`default_nettype wire
